>>> hdl/ordered_value_set_core_defines.svh
// Assertion macros used by the checker file.
`ifndef ORDERED_VALUE_SET_CORE_DEFINES_SVH
`define ORDERED_VALUE_SET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OVS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ordered_value_set_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define OVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ordered_value_set_core: next-cycle check failed");

`endif

>>> hdl/ovs_pkg.sv
`timescale 1ns / 1ps

package ovs_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [7:0]  position;
    } ovs_in_t;

    typedef struct packed {
        logic        present;
        logic [31:0] data;
        logic [4:0]  count;
        logic [1:0]  status;
    } ovs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SEARCH,
        ST_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } ovs_state_t;

endpackage

>>> hdl/ovs_mem.sv
`timescale 1ns / 1ps

// Entry store: one write port, one read port, registered read data.
module ovs_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ordered_value_set_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  ovs_pkg::ovs_in_t  (kind, value, position)
// m_        out        m_valid / m_ready  ovs_pkg::ovs_out_t (present, data, count, status)
//
// Read by index: the entry passes through RD_WAIT to DONE; out of range goes straight to DONE.
// Insert, query: a SEARCH and a CMP step per entry compared; remove adds an SH_RD and
// SH_WR step per entry moved down. The pace is set by the single read port of the
// entry memory, which the scan and the compaction both go through.
// Reset clears the state, the entry count and the output valid only; memory contents are never read unwritten.
// One item at a time; a waiting result is held in the output register and the
// next item is taken once the previous result has moved there.
module ordered_value_set_core #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ovs_pkg::ovs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ovs_pkg::ovs_out_t m_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    ovs_pkg::ovs_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      idx_inc;
    logic [1:0]            kind_reg, kind_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  present_reg, present_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           data_reg, data_next;
    logic                  m_valid_reg, m_valid_next;
    ovs_pkg::ovs_out_t     m_data_reg, m_data_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [VALUE_BITS-1:0] mem_rdata;

    ovs_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idx_inc = CNT_W'(idx_reg + 1'b1);
    assign s_ready = (state_reg == ovs_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ovs_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        present_next = present_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IDX_W-1:0];
        mem_wdata    = value_reg;
        mem_raddr    = idx_reg[IDX_W-1:0];

        case (state_reg)
            ovs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next    = s_data.kind;
                    value_next   = VALUE_BITS'(s_data.value);
                    idx_next     = '0;
                    present_next = 1'b0;
                    status_next  = ovs_pkg::STATUS_OK;
                    data_next    = '0;
                    if (s_data.kind == ovs_pkg::KIND_READ) begin
                        if (CMP_W'(s_data.position) < CMP_W'(count_reg)) begin
                            mem_raddr  = IDX_W'(s_data.position);
                            state_next = ovs_pkg::ST_RD_WAIT;
                        end else begin
                            status_next = ovs_pkg::STATUS_RANGE;
                            state_next  = ovs_pkg::ST_DONE;
                        end
                    end else begin
                        state_next = ovs_pkg::ST_SEARCH;
                    end
                end
            end
            ovs_pkg::ST_RD_WAIT: begin
                data_next  = 32'(mem_rdata);
                state_next = ovs_pkg::ST_DONE;
            end
            ovs_pkg::ST_SEARCH: begin
                if (idx_reg == count_reg) begin
                    // scan ran off the end: value absent
                    if (kind_reg == ovs_pkg::KIND_INSERT) begin
                        if (count_reg < CAP_CNT) begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            count_next = CNT_W'(count_reg + 1'b1);
                        end else begin
                            status_next = ovs_pkg::STATUS_FULL;
                        end
                    end
                    state_next = ovs_pkg::ST_DONE;
                end else begin
                    state_next = ovs_pkg::ST_CMP;
                end
            end
            ovs_pkg::ST_CMP: begin
                if (mem_rdata == value_reg) begin
                    present_next = 1'b1;
                    if (kind_reg == ovs_pkg::KIND_REMOVE) begin
                        state_next = ovs_pkg::ST_SH_RD;
                    end else begin
                        state_next = ovs_pkg::ST_DONE;
                    end
                end else begin
                    idx_next   = idx_inc;
                    state_next = ovs_pkg::ST_SEARCH;
                end
            end
            ovs_pkg::ST_SH_RD: begin
                // close the gap: move entry idx+1 down to idx
                if (idx_inc == count_reg) begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    state_next = ovs_pkg::ST_DONE;
                end else begin
                    mem_raddr  = idx_inc[IDX_W-1:0];
                    state_next = ovs_pkg::ST_SH_WR;
                end
            end
            ovs_pkg::ST_SH_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = ovs_pkg::ST_SH_RD;
            end
            ovs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.present = present_reg;
                    m_data_next.data    = data_reg;
                    m_data_next.count   = 5'(count_reg);
                    m_data_next.status  = status_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ovs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ovs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ovs_checker.sv
`timescale 1ns / 1ps
`include "ordered_value_set_core_defines.svh"

module ovs_checker #(
    parameter int CAPACITY = 16
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ovs_pkg::ovs_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ovs_pkg::ovs_out_t m_data
);

    logic s_accept;

    assign s_accept = s_valid && s_ready;

    // one item in flight: no second accept straight after the first
    `OVS_ASSERT_NEXT(a_one_item, aclk, aresetn, s_accept, !s_ready)
    `OVS_ASSERT_NEXT(a_input_held, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data))
    `OVS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `OVS_ASSERT_NOW(a_full_reject, aclk, aresetn,
        m_valid && (m_data.status == ovs_pkg::STATUS_FULL),
        !m_data.present && (m_data.count == 5'(CAPACITY)) && (m_data.data == 32'd0))
    `OVS_ASSERT_NOW(a_range_empty, aclk, aresetn,
        m_valid && (m_data.status == ovs_pkg::STATUS_RANGE),
        !m_data.present && (m_data.data == 32'd0))

endmodule

bind ordered_value_set_core ovs_checker #(
    .CAPACITY (CAPACITY)
) u_ovs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
